@@ rtl/tone_noise_sound_generator_top_defines.svh @@
// assertion macros for the tone and noise sound generator
// used by the port-level checker, no other dependencies
`ifndef TONE_NOISE_SOUND_GENERATOR_TOP_DEFINES_SVH
`define TONE_NOISE_SOUND_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TNSG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define TNSG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle implication failed");

`endif

@@ rtl/tnsg_pkg.sv @@
// shared types, constants and the amplitude table of the sound generator
// no dependencies
`default_nettype none

package tnsg_pkg;

	localparam int DIV_W = 10;
	localparam int ATT_W = 4;
	localparam int AMP_W = 10;
	localparam int SAMPLE_W = 12;
	localparam int LFSR_W = 16;
	localparam int NUM_CH = 4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] TONE3_CH = 2'd2;
	localparam logic [1:0] NOISE_CH = 2'd3;

	localparam logic [1:0] RATE_16 = 2'd0;
	localparam logic [1:0] RATE_32 = 2'd1;
	localparam logic [1:0] RATE_64 = 2'd2;
	localparam logic [1:0] RATE_TONE3 = 2'd3;

	localparam logic [DIV_W-1:0] NOISE_DIV_16 = 10'h010;
	localparam logic [DIV_W-1:0] NOISE_DIV_32 = 10'h020;
	localparam logic [DIV_W-1:0] NOISE_DIV_64 = 10'h040;

	localparam logic [ATT_W-1:0] ATT_SILENT = 4'hF;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h4000;
	localparam logic [LFSR_W-1:0] TAP_WHITE = 16'hF037;
	localparam logic [LFSR_W-1:0] TAP_PERIODIC = 16'h8000;

	// one request after the input register, decoded
	typedef struct packed {
		logic wr;
		logic tick;
		logic [7:0] data;
	} item_t;

	// programmed channel settings
	typedef struct packed {
		logic [NUM_CH-1:0][DIV_W-1:0] divider;
		logic [NUM_CH-1:0][ATT_W-1:0] atten;
		logic white;
		logic follows_tone3;
	} regs_t;

	function automatic logic [AMP_W-1:0] amp_of(input logic [ATT_W-1:0] att);
		logic [AMP_W-1:0] a;
		case (att)
			4'd0: a = 10'd1023;
			4'd1: a = 10'd813;
			4'd2: a = 10'd646;
			4'd3: a = 10'd513;
			4'd4: a = 10'd407;
			4'd5: a = 10'd323;
			4'd6: a = 10'd257;
			4'd7: a = 10'd205;
			4'd8: a = 10'd162;
			4'd9: a = 10'd128;
			4'd10: a = 10'd102;
			4'd11: a = 10'd81;
			4'd12: a = 10'd64;
			4'd13: a = 10'd51;
			4'd14: a = 10'd40;
			default: a = 10'd0;
		endcase
		return a;
	endfunction

endpackage

`default_nettype wire

@@ rtl/tnsg_cmd_regs.sv @@
// command byte decode and the channel setting registers
// depends on tnsg_pkg
`default_nettype none

module tnsg_cmd_regs (
	input  logic clk,
	input  logic arst_n,
	input  tnsg_pkg::item_t item,
	output tnsg_pkg::regs_t regs
);
	import tnsg_pkg::*;

	logic [1:0] latched_q;
	regs_t regs_q;
	logic [1:0] ch;

	assign ch = item.data[6:5];
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= 2'd0;
			regs_q.divider <= '0;
			regs_q.atten <= {NUM_CH{ATT_SILENT}};
			regs_q.white <= 1'b0;
			regs_q.follows_tone3 <= 1'b0;
		end else if (item.wr) begin
			if (item.data[7]) begin
				latched_q <= ch;
				if (item.data[4]) begin
					regs_q.atten[ch] <= item.data[3:0];
				end else if (ch != NOISE_CH) begin
					regs_q.divider[ch][3:0] <= item.data[3:0];
				end else begin
					regs_q.white <= item.data[2];
					regs_q.follows_tone3 <= (item.data[1:0] == RATE_TONE3);
					case (item.data[1:0])
						RATE_16: regs_q.divider[NOISE_CH] <= NOISE_DIV_16;
						RATE_32: regs_q.divider[NOISE_CH] <= NOISE_DIV_32;
						RATE_64: regs_q.divider[NOISE_CH] <= NOISE_DIV_64;
						default: ;
					endcase
				end
			end else if (latched_q != NOISE_CH) begin
				// data byte sets the high divider bits of the latched tone
				regs_q.divider[latched_q][DIV_W-1:4] <= item.data[5:0];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tnsg_tone_ch.sv @@
// one square-wave tone channel: down-counter and output level
// depends on tnsg_pkg
`default_nettype none

module tnsg_tone_ch (
	input  logic clk,
	input  logic arst_n,
	input  logic tick,
	input  logic [tnsg_pkg::DIV_W-1:0] divider,
	output logic level_nxt
);
	import tnsg_pkg::*;

	logic [DIV_W-1:0] cnt_q;
	logic lvl_q;
	logic reload;

	assign reload = (cnt_q == '0);
	assign level_nxt = (tick && reload) ? !lvl_q : lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			lvl_q <= 1'b0;
		end else if (tick) begin
			lvl_q <= level_nxt;
			cnt_q <= reload ? divider : cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tnsg_noise_ch.sv @@
// noise channel: down-counter and 16-bit shift register
// depends on tnsg_pkg
`default_nettype none

module tnsg_noise_ch (
	input  logic clk,
	input  logic arst_n,
	input  logic tick,
	input  logic [tnsg_pkg::DIV_W-1:0] divider,
	input  logic [tnsg_pkg::DIV_W-1:0] tone3_divider,
	input  logic follows_tone3,
	input  logic white,
	output logic level_nxt
);
	import tnsg_pkg::*;

	logic [DIV_W-1:0] cnt_q;
	logic [LFSR_W-1:0] sr_q;
	logic [LFSR_W-1:0] sr_nxt;
	logic [LFSR_W-1:0] taps;
	logic lvl_q;
	logic reload;

	assign reload = (cnt_q == '0);
	assign taps = white ? TAP_WHITE : TAP_PERIODIC;
	assign sr_nxt = {1'b0, sr_q[LFSR_W-1:1]} ^ (sr_q[0] ? taps : '0);
	assign level_nxt = (tick && reload) ? sr_q[0] : lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sr_q <= LFSR_SEED;
			lvl_q <= 1'b0;
		end else if (tick) begin
			lvl_q <= level_nxt;
			if (reload) begin
				cnt_q <= follows_tone3 ? tone3_divider : divider;
				sr_q <= sr_nxt;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tnsg_mixer.sv @@
// amplitude lookup, four-way sum and the sample output register
// depends on tnsg_pkg
`default_nettype none

module tnsg_mixer (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  logic [tnsg_pkg::NUM_CH-1:0] level,
	input  logic [tnsg_pkg::NUM_CH-1:0][tnsg_pkg::ATT_W-1:0] atten,
	input  logic sample_stall,
	output logic sample_valid,
	output logic [tnsg_pkg::SAMPLE_W-1:0] sample,
	output logic out_free
);
	import tnsg_pkg::*;

	logic valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [NUM_CH-1:0][AMP_W-1:0] amp;
	logic [SAMPLE_W-1:0] sum;

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			amp[i] = level[i] ? amp_of(atten[i]) : '0;
		end
	end

	assign sum = (SAMPLE_W'(amp[0]) + SAMPLE_W'(amp[1]))
		+ (SAMPLE_W'(amp[2]) + SAMPLE_W'(amp[3]));

	assign out_free = !valid_q || !sample_stall;
	assign sample_valid = valid_q;
	assign sample = sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!sample_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_q <= sum;
		end
	end

endmodule

`default_nettype wire

@@ rtl/tone_noise_sound_generator_top.sv @@
// a tick request passes the input register, then its sample lands in the output register
// throughput: one request per cycle, writes and ticks alike, set by the single update stage;
// a tick stalls the input while the sample before it is held; writes pass a waiting sample
// reset: dividers and counters zero, channels silent, levels low, noise register at 0x4000
// depends on tnsg_pkg, tnsg_cmd_regs, tnsg_tone_ch, tnsg_noise_ch, tnsg_mixer
`default_nettype none

module tone_noise_sound_generator_top (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  logic op,
	input  logic [7:0] data,
	output logic sample_valid,
	input  logic sample_stall,
	output logic [tnsg_pkg::SAMPLE_W-1:0] sample
);
	import tnsg_pkg::*;

	logic valid_s1;
	logic op_s1;
	logic [7:0] data_s1;
	logic proc_ok;
	logic accept;
	logic fire;
	logic out_free;
	item_t item;
	regs_t regs;
	logic [NUM_CH-1:0] level_nxt;

	// a write never needs the output slot, a tick needs it free
	assign proc_ok = !valid_s1 || (op_s1 == OP_WRITE) || out_free;
	assign item_stall = !proc_ok;
	assign accept = item_valid && proc_ok;
	assign fire = valid_s1 && proc_ok;

	assign item.wr = fire && (op_s1 == OP_WRITE);
	assign item.tick = fire && (op_s1 == OP_TICK);
	assign item.data = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (proc_ok) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op;
			data_s1 <= data;
		end
	end

	tnsg_cmd_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.regs(regs)
	);

	for (genvar g = 0; g < NUM_CH - 1; g++) begin : g_tone
		tnsg_tone_ch u_tone (
			.clk(clk),
			.arst_n(arst_n),
			.tick(item.tick),
			.divider(regs.divider[g]),
			.level_nxt(level_nxt[g])
		);
	end

	tnsg_noise_ch u_noise (
		.clk(clk),
		.arst_n(arst_n),
		.tick(item.tick),
		.divider(regs.divider[NOISE_CH]),
		.tone3_divider(regs.divider[TONE3_CH]),
		.follows_tone3(regs.follows_tone3),
		.white(regs.white),
		.level_nxt(level_nxt[NOISE_CH])
	);

	tnsg_mixer u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.load(item.tick),
		.level(level_nxt),
		.atten(regs.atten),
		.sample_stall(sample_stall),
		.sample_valid(sample_valid),
		.sample(sample),
		.out_free(out_free)
	);

endmodule

`default_nettype wire

@@ rtl/tnsg_checker.sv @@
// port-level checks of the sound generator, bound to its top level
// depends on tnsg_pkg and tone_noise_sound_generator_top_defines.svh
`default_nettype none

`include "tone_noise_sound_generator_top_defines.svh"

module tnsg_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_stall,
	input  logic op,
	input  logic [7:0] data,
	input  logic sample_valid,
	input  logic sample_stall,
	input  logic [tnsg_pkg::SAMPLE_W-1:0] sample
);
	import tnsg_pkg::*;

	logic tick_req;

	assign tick_req = item_valid && !item_stall && (op == OP_TICK);

	// a waiting sample holds until taken
	`TNSG_ASSERT_NXT(a_hold, sample_valid && sample_stall, sample_valid && $stable(sample))
	// four channels at full level never pass 4 x 1023
	`TNSG_ASSERT_IMP(a_range, sample_valid, sample <= 12'd4092)
	// an accepted tick must have a sample waiting once it has passed the input and output registers
	`TNSG_ASSERT_NXT(a_tick_out, tick_req, ##1 sample_valid)
	// a sample only appears after a request entered
	`TNSG_ASSERT_IMP(a_no_spurious, $rose(sample_valid), $past(tick_req, 2) || $past(tick_req, 3)
		|| $past(item_valid && !item_stall, 2))

endmodule

bind tone_noise_sound_generator_top tnsg_checker u_tnsg_chk (.*);

`default_nettype wire

@@ sim/tb.sv @@
// testbench for tone_noise_sound_generator_top: command writes and sample ticks are
// checked against a cycle-free predictor of the channel counters, levels and noise register
// depends on tnsg_pkg and the rtl of the sound generator
`timescale 1ns / 100ps

module tb;
	import tnsg_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic op = OP_WRITE;
	logic [7:0] data = 8'h00;
	logic sample_valid;
	logic sample_stall = 1'b0;
	logic [SAMPLE_W-1:0] sample;

	// amplitude by attenuation, entry 15 first
	localparam logic [15:0][AMP_W-1:0] AMP_BY_ATT = {
		10'd0, 10'd40, 10'd51, 10'd64, 10'd81, 10'd102, 10'd128, 10'd162,
		10'd205, 10'd257, 10'd323, 10'd407, 10'd513, 10'd646, 10'd813, 10'd1023
	};

	// predicted chip state
	logic [1:0] pred_latch;
	logic [DIV_W-1:0] pred_div [NUM_CH];
	logic [ATT_W-1:0] pred_att [NUM_CH];
	logic pred_white;
	logic pred_follow;
	logic [LFSR_W-1:0] pred_lfsr;
	logic [DIV_W-1:0] pred_count [NUM_CH];
	logic pred_level [NUM_CH];

	logic [SAMPLE_W-1:0] pending_samples [$];
	int mismatches = 0;
	int requests_sent = 0;
	int hold_left = 0;
	bit steady = 1'b0;

	tone_noise_sound_generator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.data(data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic reset_prediction();
		pred_latch = 2'd0;
		pred_white = 1'b0;
		pred_follow = 1'b0;
		pred_lfsr = LFSR_SEED;
		for (int i = 0; i < NUM_CH; i++) begin
			pred_div[i] = '0;
			pred_att[i] = ATT_SILENT;
			pred_count[i] = '0;
			pred_level[i] = 1'b0;
		end
	endtask

	task automatic latch_command(input logic [7:0] cmd);
		logic [1:0] ch;
		if (cmd[7]) begin
			ch = cmd[6:5];
			pred_latch = ch;
			if (cmd[4]) begin
				pred_att[ch] = cmd[3:0];
			end else if (ch != NOISE_CH) begin
				pred_div[ch][3:0] = cmd[3:0];
			end else begin
				pred_white = cmd[2];
				pred_follow = 1'b0;
				case (cmd[1:0])
					RATE_16: pred_div[NOISE_CH] = NOISE_DIV_16;
					RATE_32: pred_div[NOISE_CH] = NOISE_DIV_32;
					RATE_64: pred_div[NOISE_CH] = NOISE_DIV_64;
					default: pred_follow = 1'b1;
				endcase
			end
		end else if (pred_latch != NOISE_CH) begin
			pred_div[pred_latch][9:4] = cmd[5:0];
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] advance_tick();
		logic [SAMPLE_W-1:0] sum;
		logic [LFSR_W-1:0] shifted;
		logic out_bit;
		sum = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			if (pred_count[i] != 0) begin
				pred_count[i] = pred_count[i] - 1'b1;
			end else if (i != NOISE_CH) begin
				pred_count[i] = pred_div[i];
				pred_level[i] = ~pred_level[i];
			end else begin
				out_bit = pred_lfsr[0];
				shifted = pred_lfsr >> 1;
				if (out_bit)
					shifted = shifted ^ (pred_white ? TAP_WHITE : TAP_PERIODIC);
				pred_lfsr = shifted;
				pred_level[i] = out_bit;
				pred_count[i] = pred_follow ? pred_div[TONE3_CH] : pred_div[NOISE_CH];
			end
		end
		for (int i = 0; i < NUM_CH; i++) begin
			if (pred_level[i])
				sum = sum + AMP_BY_ATT[pred_att[i]];
		end
		return sum;
	endfunction

	// one request, held until taken, then folded into the prediction
	task automatic send_request(input logic req_op, input logic [7:0] req_data);
		int gap;
		@(negedge clk);
		item_valid = 1'b1;
		op = req_op;
		data = req_data;
		do @(posedge clk); while (item_stall);
		if (req_op == OP_TICK)
			pending_samples.push_back(advance_tick());
		else
			latch_command(req_data);
		requests_sent++;
		if (!steady && $urandom_range(0, 99) < 25) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			item_valid = 1'b0;
			op = 1'($urandom_range(0, 1));
			data = 8'($urandom_range(0, 255));
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic set_atten(input logic [1:0] ch, input logic [3:0] att);
		send_request(OP_WRITE, {1'b1, ch, 1'b1, att});
	endtask

	task automatic set_divider(input logic [1:0] ch, input logic [DIV_W-1:0] div);
		logic junk;
		junk = 1'($urandom_range(0, 1));
		send_request(OP_WRITE, {1'b1, ch, 1'b0, div[3:0]});
		send_request(OP_WRITE, {1'b0, junk, div[9:4]});
	endtask

	task automatic set_noise(input logic white, input logic [1:0] rate);
		logic junk;
		junk = 1'($urandom_range(0, 1));
		send_request(OP_WRITE, {1'b1, NOISE_CH, 1'b0, junk, white, rate});
	endtask

	task automatic run_ticks(input int n);
		repeat (n) send_request(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	// receiver side: long hold-off when asked, no stalls while steady, otherwise random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			sample_stall = 1'b1;
			hold_left = hold_left - 1;
		end else if (steady) begin
			sample_stall = 1'b0;
		end else begin
			sample_stall = ($urandom_range(0, 99) < 25);
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall) begin
			if (pending_samples.size() == 0) begin
				$error("sample: unexpected result %0d", sample);
				mismatches++;
			end else begin
				if (sample !== pending_samples[0]) begin
					$error("sample mismatch: expected %0d, actual %0d",
						pending_samples[0], sample);
					mismatches++;
				end
				void'(pending_samples.pop_front());
			end
		end
	end

	task automatic test_reset_state();
		send_request(OP_TICK, 8'hFF);
		send_request(OP_TICK, 8'h00);
	endtask

	task automatic test_attenuation();
		for (int ch = 0; ch < NUM_CH; ch++)
			set_atten(ch[1:0], 4'd0);
		run_ticks(2);
	endtask

	task automatic test_tone_dividers();
		set_divider(2'd0, 10'h3FF);
		set_divider(2'd1, 10'h000);
		set_divider(2'd2, 10'h001);
		run_ticks(3);
	endtask

	task automatic test_noise_modes();
		set_noise(1'b1, RATE_TONE3);
		// data byte with noise latched changes nothing
		send_request(OP_WRITE, 8'h7F);
		run_ticks(2);
		set_noise(1'b0, RATE_16);
		set_noise(1'b1, RATE_32);
		set_noise(1'b0, RATE_64);
		run_ticks(1);
	endtask

	// receiver holds off while ticks keep coming, so the block has to stall its input
	task automatic test_backpressure();
		steady = 1'b1;
		hold_left = 80;
		run_ticks(40);
		steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		int first;
		int kind;
		logic [3:0] nib;
		logic [7:0] byte_val;
		logic [DIV_W-1:0] div;
		first = requests_sent;
		while (requests_sent - first < 1785) begin
			steady = (requests_sent - first >= 600) && (requests_sent - first < 900);
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				run_ticks($urandom_range(1, 8));
			end else if (kind < 68) begin
				// short periods mostly, so levels toggle often
				if ($urandom_range(0, 99) < 70)
					div = DIV_W'($urandom_range(0, 15));
				else
					div = DIV_W'($urandom_range(0, 1023));
				set_divider(2'($urandom_range(0, 2)), div);
			end else if (kind < 78) begin
				set_atten(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
			end else if (kind < 85) begin
				nib = 4'($urandom_range(0, 15));
				send_request(OP_WRITE, {1'b1, NOISE_CH, 1'b0, nib});
			end else if (kind < 93) begin
				byte_val = 8'($urandom_range(0, 255));
				byte_val[7] = 1'b0;
				send_request(OP_WRITE, byte_val);
			end else begin
				send_request(OP_WRITE, 8'($urandom_range(0, 255)));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		int waited;
		reset_prediction();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_attenuation();
		test_tone_dividers();
		test_noise_modes();
		test_backpressure();
		test_random_traffic();

		@(negedge clk);
		item_valid = 1'b0;
		waited = 0;
		while (pending_samples.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_samples.size() != 0) begin
			$error("sample: %0d results never arrived", pending_samples.size());
			mismatches++;
		end
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("[tone_noise_sound_generator_top] OK");
		else
			$display("[tone_noise_sound_generator_top] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[tone_noise_sound_generator_top] ERROR");
		$finish;
	end

endmodule
